FILE: rtl/pcsv_pkg.sv
// Shared types, constants and CRC/signature helpers for the PNG chunk stream validator.
package pcsv_pkg;

	localparam int QDEPTH = 4;
	localparam int QADDR_W = $clog2(QDEPTH);
	localparam int QCOUNT_W = $clog2(QDEPTH + 1);

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] TYPE_IEND = 32'h49454E44;
	localparam logic [31:0] IHDR_DATA_LEN = 32'd13;
	localparam logic [31:0] SIG_LEN = 32'd16;

	localparam logic [2:0] ST_VALID = 3'd0;
	localparam logic [2:0] ST_NO_SIG = 3'd1;
	localparam logic [2:0] ST_TRUNC_IHDR = 3'd2;
	localparam logic [2:0] ST_IHDR_CRC_BAD = 3'd3;
	localparam logic [2:0] ST_BOUNDS = 3'd4;
	localparam logic [2:0] ST_CHUNK_CRC_BAD = 3'd5;
	localparam logic [2:0] ST_NO_IEND = 3'd6;

	// queue entry: raw byte, framing marks and the byte's CRC contribution
	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first_byte;
		logic        last_byte;
		logic [31:0] byte_crc;
	} q_item_t;

	// eight reflected shift steps of the CRC-32 register on a byte value
	function automatic logic [31:0] crc_tab(input logic [7:0] idx);
		logic [31:0] c;
		c = {24'd0, idx};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// magic, IHDR length and IHDR type
	function automatic logic [7:0] sig_byte(input logic [3:0] idx);
		logic [7:0] v;
		case (idx)
			4'd0: v = 8'h89;
			4'd1: v = 8'h50;
			4'd2: v = 8'h4E;
			4'd3: v = 8'h47;
			4'd4: v = 8'h0D;
			4'd5: v = 8'h0A;
			4'd6: v = 8'h1A;
			4'd7: v = 8'h0A;
			4'd8: v = 8'h00;
			4'd9: v = 8'h00;
			4'd10: v = 8'h00;
			4'd11: v = 8'h0D;
			4'd12: v = 8'h49;
			4'd13: v = 8'h48;
			4'd14: v = 8'h44;
			4'd15: v = 8'h52;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/pcsv_ifs.sv
// Stream interfaces for the byte input and the result output.
interface pcsv_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;
	logic       last_byte;

	modport source(output valid, data_byte, first_byte, last_byte, input ready);
	modport sink(input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface pcsv_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] image_width;
	logic [31:0] image_height;
	logic [31:0] total_length;

	modport source(output valid, status, image_width, image_height, total_length, input ready);
	modport sink(input valid, status, image_width, image_height, total_length, output ready);
endinterface

FILE: rtl/pcsv_front.sv
// Front end: takes byte transactions, precomputes their CRC term and feeds the queue.
module pcsv_front import pcsv_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	pcsv_byte_if.sink       stream,
	output q_item_t         push_item,
	output logic            push,
	input  logic            q_ready
);

	logic    valid_s1;
	q_item_t item_s1;
	logic    take;

	assign stream.ready = !valid_s1 || q_ready;
	assign take = stream.valid && stream.ready;
	assign push = valid_s1 && q_ready;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	// CRC is linear: the byte's own term is looked up here, the register term in the back end
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.data_byte <= stream.data_byte;
			item_s1.first_byte <= stream.first_byte;
			item_s1.last_byte <= stream.last_byte;
			item_s1.byte_crc <= crc_tab(stream.data_byte);
		end
	end

endmodule

FILE: rtl/pcsv_queue.sv
// Short queue between front end and parser.
module pcsv_queue import pcsv_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  q_item_t push_item,
	input  logic    push,
	output logic    q_ready,
	output q_item_t pop_item,
	output logic    q_valid,
	input  logic    pop
);

	q_item_t               entries_q [QDEPTH];
	logic [QADDR_W-1:0]    wr_ptr_q;
	logic [QADDR_W-1:0]    rd_ptr_q;
	logic [QCOUNT_W-1:0]   count_q;

	assign q_ready = count_q != QCOUNT_W'(QDEPTH);
	assign q_valid = count_q != '0;
	assign pop_item = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCOUNT_W'(QDEPTH)) else $error("queue count beyond depth");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0) else $error("pop from empty queue");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1) else $error("queue fill lost");
`endif

endmodule

FILE: rtl/pcsv_back.sv
// Back end: signature, IHDR and chunk walk with CRC-32, plus the result register.
module pcsv_back import pcsv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  q_item_t    item,
	input  logic       q_valid,
	output logic       pop,
	pcsv_res_if.source result
);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_SIG = 3'd1;
	localparam logic [2:0] PH_IHDR_DATA = 3'd2;
	localparam logic [2:0] PH_IHDR_CRC = 3'd3;
	localparam logic [2:0] PH_CLEN = 3'd4;
	localparam logic [2:0] PH_CTYPE = 3'd5;
	localparam logic [2:0] PH_CDATA = 3'd6;
	localparam logic [2:0] PH_CCRC = 3'd7;

	logic [2:0]  phase_q, ph;
	logic [31:0] fc_q, fc, fc_inc;
	logic [31:0] cl_q, cl;
	logic [31:0] ct_q, ct;
	logic [31:0] crc_q, crc, crc_upd;
	logic [31:0] scw_q, scw;
	logic [31:0] w_q, w;
	logic [31:0] h_q, h;
	logic [31:0] bt_q, bt;
	logic        emit;
	logic [2:0]  st;
	logic        load;

	logic        out_valid_q;
	logic [2:0]  res_status_q;
	logic [31:0] res_width_q;
	logic [31:0] res_height_q;
	logic [31:0] res_total_q;

	// parser holds while a finished result is still waiting
	assign pop = q_valid && (!out_valid_q || result.ready);
	assign load = pop && emit;

	always_comb begin
		ph = phase_q;
		fc = fc_q;
		cl = cl_q;
		ct = ct_q;
		crc = crc_q;
		scw = scw_q;
		w = w_q;
		h = h_q;
		bt = bt_q;
		emit = 1'b0;
		st = ST_VALID;
		if (item.first_byte) begin
			ph = PH_SIG;
			fc = '0;
			cl = '0;
			ct = '0;
			crc = '1;
			scw = '0;
			w = '0;
			h = '0;
			bt = '0;
		end
		crc_upd = (crc >> 8) ^ crc_tab(crc[7:0]) ^ item.byte_crc;
		fc_inc = fc + 32'd1;
		if (ph != PH_IDLE) begin
			if (bt != '1) begin
				bt = bt + 32'd1;
			end
			case (ph)
				PH_SIG: begin
					if (item.data_byte != sig_byte(fc[3:0])) begin
						emit = 1'b1;
						st = ST_NO_SIG;
					end else begin
						if (fc >= 32'd12) begin
							crc = crc_upd;
						end
						fc = fc_inc;
						if (fc_inc >= SIG_LEN) begin
							ph = PH_IHDR_DATA;
							fc = '0;
							if (item.last_byte) begin
								emit = 1'b1;
								st = ST_TRUNC_IHDR;
							end
						end else if (item.last_byte) begin
							emit = 1'b1;
							st = ST_NO_SIG;
						end
					end
				end
				PH_IHDR_DATA: begin
					crc = crc_upd;
					if (fc < 32'd4) begin
						w = {w[23:0], item.data_byte};
					end else if (fc < 32'd8) begin
						h = {h[23:0], item.data_byte};
					end
					fc = fc_inc;
					if (fc_inc >= IHDR_DATA_LEN) begin
						ph = PH_IHDR_CRC;
						fc = '0;
					end
					if (item.last_byte) begin
						emit = 1'b1;
						st = ST_TRUNC_IHDR;
					end
				end
				PH_IHDR_CRC: begin
					scw = {scw[23:0], item.data_byte};
					fc = fc_inc;
					if (fc_inc >= 32'd4) begin
						if (~crc != scw) begin
							emit = 1'b1;
							st = ST_IHDR_CRC_BAD;
						end else begin
							ph = PH_CLEN;
							fc = '0;
							if (item.last_byte) begin
								emit = 1'b1;
								st = ST_NO_IEND;
							end
						end
					end else if (item.last_byte) begin
						emit = 1'b1;
						st = ST_TRUNC_IHDR;
					end
				end
				PH_CLEN: begin
					cl = {cl[23:0], item.data_byte};
					fc = fc_inc;
					if (fc_inc >= 32'd4) begin
						ph = PH_CTYPE;
						fc = '0;
						crc = '1;
					end
					if (item.last_byte) begin
						emit = 1'b1;
						st = ST_NO_IEND;
					end
				end
				PH_CTYPE: begin
					ct = {ct[23:0], item.data_byte};
					crc = crc_upd;
					fc = fc_inc;
					if (fc_inc >= 32'd4) begin
						fc = '0;
						ph = (cl == '0) ? PH_CCRC : PH_CDATA;
					end
					if (item.last_byte) begin
						emit = 1'b1;
						st = ST_NO_IEND;
					end
				end
				PH_CDATA: begin
					crc = crc_upd;
					fc = fc_inc;
					if (fc_inc >= cl) begin
						ph = PH_CCRC;
						fc = '0;
					end
					// under 12 bytes of the chunk seen counts as a missing IEND
					if (item.last_byte) begin
						emit = 1'b1;
						st = (fc_inc < 32'd4) ? ST_NO_IEND : ST_BOUNDS;
					end
				end
				PH_CCRC: begin
					scw = {scw[23:0], item.data_byte};
					fc = fc_inc;
					if (fc_inc >= 32'd4) begin
						if (~crc != scw) begin
							emit = 1'b1;
							st = ST_CHUNK_CRC_BAD;
						end else if (ct == TYPE_IEND) begin
							emit = 1'b1;
							st = ST_VALID;
						end else begin
							ph = PH_CLEN;
							fc = '0;
							cl = '0;
							ct = '0;
							if (item.last_byte) begin
								emit = 1'b1;
								st = ST_NO_IEND;
							end
						end
					end else if (item.last_byte) begin
						emit = 1'b1;
						// fc_inc is at most 3 here, so two low bits cover the sum
						st = ((cl[31:2] == '0) &&
							(({1'b0, cl[1:0]} + {1'b0, fc_inc[1:0]}) < 3'd4)) ?
							ST_NO_IEND : ST_BOUNDS;
					end
				end
				default: begin
					ph = PH_IDLE;
				end
			endcase
			if (emit) begin
				ph = PH_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			fc_q <= '0;
			cl_q <= '0;
			ct_q <= '0;
			crc_q <= '1;
			scw_q <= '0;
			w_q <= '0;
			h_q <= '0;
			bt_q <= '0;
		end else if (pop) begin
			phase_q <= ph;
			fc_q <= fc;
			cl_q <= cl;
			ct_q <= ct;
			crc_q <= crc;
			scw_q <= scw;
			w_q <= w;
			h_q <= h;
			bt_q <= bt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_status_q <= st;
			res_width_q <= w;
			res_height_q <= h;
			res_total_q <= (st == ST_VALID) ? bt : '0;
		end
	end

	assign result.valid = out_valid_q;
	assign result.status = res_status_q;
	assign result.image_width = res_width_q;
	assign result.image_height = res_height_q;
	assign result.total_length = res_total_q;

`ifndef NO_ASSERTIONS
	a_first_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && item.first_byte && !emit) |=> phase_q == PH_SIG)
		else $error("first-marked byte did not restart the parse");
	a_len_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_status_q != ST_VALID) |-> res_total_q == '0)
		else $error("length reported on a failed parse");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |=> phase_q == $past(phase_q))
		else $error("parser advanced while result stalled");
`endif

endmodule

FILE: rtl/png_chunk_stream_validator_top.sv
// PNG chunk stream validator: one byte per cycle sustained; a byte passes an input register,
// a four-entry queue and the parser, and a result leaves from the output register, which is
// loaded by the last byte that decides it. The rate is set by the parser's CRC-32 byte
// update and framing counters; the parser stalls only while a finished result waits on the
// output, and the queue lets input keep flowing meanwhile until it fills.
module png_chunk_stream_validator_top import pcsv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	pcsv_byte_if.sink  stream,
	pcsv_res_if.source result
);

	q_item_t push_item;
	q_item_t pop_item;
	logic    push;
	logic    q_ready;
	logic    q_valid;
	logic    pop;

	pcsv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.stream    (stream),
		.push_item (push_item),
		.push      (push),
		.q_ready   (q_ready)
	);

	pcsv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_item (push_item),
		.push      (push),
		.q_ready   (q_ready),
		.pop_item  (pop_item),
		.q_valid   (q_valid),
		.pop       (pop)
	);

	pcsv_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (pop_item),
		.q_valid (q_valid),
		.pop     (pop),
		.result  (result)
	);

endmodule

FILE: tb/tb_png_chunk_stream_validator_top.sv
// Self-checking testbench for the PNG chunk stream validator: random PNG blobs, parser model, scoreboard.
module tb_png_chunk_stream_validator_top;
	import pcsv_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int LONG_HOLD = 300;
	localparam int DRAIN_CYCLES = 20;

	localparam logic [7:0] PNG_SIG [16] = '{
		8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A,
		8'h00, 8'h00, 8'h00, 8'h0D, 8'h49, 8'h48, 8'h44, 8'h52
	};

	typedef enum logic [2:0] {
		P_IDLE, P_SIG, P_IHDR_DATA, P_IHDR_CRC, P_CLEN, P_CTYPE, P_CDATA, P_CCRC
	} parse_phase_e;

	typedef enum int {
		BK_INTACT, BK_CUT, BK_FLIP, BK_TRAILING, BK_HUGE_LEN, BK_NO_LAST, BK_NOISE,
		BK_IHDR_BAD, BK_END_AT_IHDR, BK_END_AFTER_CHUNK, BK_IEND_LONG, BK_IEND_BAD,
		BK_COUNT
	} blob_kind_e;

	typedef struct {
		parse_phase_e phase;
		logic [31:0]  fcount;
		logic [31:0]  clen;
		logic [31:0]  ctype;
		logic [31:0]  crc;
		logic [31:0]  stored;
		logic [31:0]  width;
		logic [31:0]  height;
		logic [31:0]  total;
	} parse_state_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] width;
		logic [31:0] height;
		logic [31:0] length;
	} png_result_t;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
	} byte_item_t;

	logic clk;
	logic arst_n;

	pcsv_byte_if stream_if();
	pcsv_res_if  result_if();

	png_chunk_stream_validator_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_if),
		.result (result_if)
	);

	parse_state_t parser;
	byte_item_t   byte_feed[$];
	png_result_t  expected_results[$];

	int send_idle_pct;
	int recv_idle_pct;
	bit hold_request;
	bit hold_done;
	int hold_left;
	int quiet_cycles;
	int mismatches;
	int bytes_queued;
	int blobs_queued;
	int results_checked;
	int status_hits[8];

	function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] x;
		x = c ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
		end
		return x;
	endfunction

	function automatic void parser_reset();
		parser.phase = P_IDLE;
		parser.fcount = '0;
		parser.clen = '0;
		parser.ctype = '0;
		parser.crc = '1;
		parser.stored = '0;
		parser.width = '0;
		parser.height = '0;
		parser.total = '0;
	endfunction

	// one byte through the parser model; returns 1 when the byte finishes a parse
	function automatic bit advance_parser(input logic [7:0] b, input logic first,
			input logic last, output png_result_t r);
		bit done;
		logic [2:0] st;
		longint seen;
		done = 0;
		st = ST_VALID;
		r = '0;
		if (first) begin
			parser_reset();
			parser.phase = P_SIG;
		end
		if (parser.phase == P_IDLE)
			return 0;
		if (parser.total != '1)
			parser.total++;
		case (parser.phase)
			P_SIG: begin
				if (b != PNG_SIG[parser.fcount[3:0]]) begin
					done = 1;
					st = ST_NO_SIG;
				end else begin
					if (parser.fcount >= 12)
						parser.crc = crc32_byte(parser.crc, b);
					parser.fcount++;
					if (parser.fcount >= 16) begin
						parser.phase = P_IHDR_DATA;
						parser.fcount = '0;
					end
					if (last) begin
						done = 1;
						st = (parser.phase == P_IHDR_DATA) ? ST_TRUNC_IHDR : ST_NO_SIG;
					end
				end
			end
			P_IHDR_DATA: begin
				parser.crc = crc32_byte(parser.crc, b);
				if (parser.fcount < 4)
					parser.width = {parser.width[23:0], b};
				else if (parser.fcount < 8)
					parser.height = {parser.height[23:0], b};
				parser.fcount++;
				if (parser.fcount >= 13) begin
					parser.phase = P_IHDR_CRC;
					parser.fcount = '0;
				end
				if (last) begin
					done = 1;
					st = ST_TRUNC_IHDR;
				end
			end
			P_IHDR_CRC: begin
				parser.stored = {parser.stored[23:0], b};
				parser.fcount++;
				if (parser.fcount >= 4) begin
					// CRC is judged before the end of the blob is
					if (~parser.crc != parser.stored) begin
						done = 1;
						st = ST_IHDR_CRC_BAD;
					end else begin
						parser.phase = P_CLEN;
						parser.fcount = '0;
						if (last) begin
							done = 1;
							st = ST_NO_IEND;
						end
					end
				end else if (last) begin
					done = 1;
					st = ST_TRUNC_IHDR;
				end
			end
			P_CLEN: begin
				parser.clen = {parser.clen[23:0], b};
				parser.fcount++;
				if (parser.fcount >= 4) begin
					parser.phase = P_CTYPE;
					parser.fcount = '0;
					parser.crc = '1;
				end
				if (last) begin
					done = 1;
					st = ST_NO_IEND;
				end
			end
			P_CTYPE: begin
				parser.ctype = {parser.ctype[23:0], b};
				parser.crc = crc32_byte(parser.crc, b);
				parser.fcount++;
				if (parser.fcount >= 4) begin
					parser.fcount = '0;
					parser.phase = (parser.clen == 0) ? P_CCRC : P_CDATA;
				end
				if (last) begin
					done = 1;
					st = ST_NO_IEND;
				end
			end
			P_CDATA: begin
				parser.crc = crc32_byte(parser.crc, b);
				parser.fcount++;
				seen = 8 + longint'(parser.fcount);
				if (parser.fcount >= parser.clen) begin
					parser.phase = P_CCRC;
					parser.fcount = '0;
				end
				if (last) begin
					done = 1;
					st = (seen < 12) ? ST_NO_IEND : ST_BOUNDS;
				end
			end
			default: begin
				parser.stored = {parser.stored[23:0], b};
				parser.fcount++;
				if (parser.fcount >= 4) begin
					// bad CRC wins over the IEND type
					if (~parser.crc != parser.stored) begin
						done = 1;
						st = ST_CHUNK_CRC_BAD;
					end else if (parser.ctype == TYPE_IEND) begin
						done = 1;
						st = ST_VALID;
					end else begin
						parser.phase = P_CLEN;
						parser.fcount = '0;
						parser.clen = '0;
						parser.ctype = '0;
						if (last) begin
							done = 1;
							st = ST_NO_IEND;
						end
					end
				end else begin
					seen = 8 + longint'(parser.clen) + longint'(parser.fcount);
					if (last) begin
						done = 1;
						st = (seen < 12) ? ST_NO_IEND : ST_BOUNDS;
					end
				end
			end
		endcase
		if (done) begin
			r.status = st;
			r.width = parser.width;
			r.height = parser.height;
			r.length = (st == ST_VALID) ? parser.total : '0;
			parser.phase = P_IDLE;
		end
		return done;
	endfunction

	function automatic void push_byte(input logic [7:0] d, input logic first, input logic last);
		byte_item_t it;
		it.data = d;
		it.first = first;
		it.last = last;
		byte_feed.push_back(it);
		bytes_queued++;
	endfunction

	function automatic void push_word(ref logic [7:0] q[$], input logic [31:0] v);
		for (int i = 3; i >= 0; i--)
			q.push_back(v[8*i +: 8]);
	endfunction

	// signature, IHDR data and IHDR CRC; a nonzero flip spoils the CRC
	function automatic void push_header(ref logic [7:0] q[$], input logic [31:0] flip);
		logic [31:0] c;
		logic [31:0] w;
		logic [31:0] h;
		logic [7:0]  d;
		c = '1;
		w = ($urandom_range(0, 4) == 0) ? {32{1'($urandom)}} : $urandom;
		h = ($urandom_range(0, 4) == 0) ? {32{1'($urandom)}} : $urandom;
		for (int i = 0; i < 16; i++) begin
			q.push_back(PNG_SIG[i]);
			if (i >= 12)
				c = crc32_byte(c, PNG_SIG[i]);
		end
		for (int i = 0; i < 13; i++) begin
			if (i < 4)
				d = w[8*(3-i) +: 8];
			else if (i < 8)
				d = h[8*(7-i) +: 8];
			else
				d = 8'($urandom);
			c = crc32_byte(c, d);
			q.push_back(d);
		end
		push_word(q, ~c ^ flip);
	endfunction

	function automatic void push_chunk(ref logic [7:0] q[$], input logic [31:0] ctype,
			input int len, input logic [31:0] flip);
		logic [31:0] c;
		logic [7:0]  d;
		c = '1;
		push_word(q, len);
		for (int i = 3; i >= 0; i--)
			c = crc32_byte(c, ctype[8*i +: 8]);
		push_word(q, ctype);
		for (int i = 0; i < len; i++) begin
			d = 8'($urandom);
			c = crc32_byte(c, d);
			q.push_back(d);
		end
		push_word(q, ~c ^ flip);
	endfunction

	task automatic queue_blob(input blob_kind_e kind);
		logic [7:0] blob[$];
		logic [31:0] one_bit;
		int n_chunks;
		int pos;
		bit mark_last;
		mark_last = 1;
		one_bit = 32'd1 << $urandom_range(0, 31);
		if (kind == BK_NOISE) begin
			repeat ($urandom_range(1, 6))
				blob.push_back(8'($urandom));
		end else begin
			push_header(blob, (kind == BK_IHDR_BAD) ? one_bit : 32'd0);
			if (kind == BK_HUGE_LEN) begin
				// length far past the end of the blob, which stops at the end of the type or inside the data
				push_word(blob, $urandom | 32'h0000_0100);
				push_word(blob, $urandom);
				repeat ($urandom_range(0, 12))
					blob.push_back(8'($urandom));
			end else if (kind != BK_IHDR_BAD && kind != BK_END_AT_IHDR) begin
				n_chunks = (kind == BK_END_AFTER_CHUNK) ? $urandom_range(1, 2) : $urandom_range(0, 2);
				repeat (n_chunks)
					push_chunk(blob, $urandom,
						($urandom_range(0, 3) == 0) ? $urandom_range(0, 24) : $urandom_range(0, 6),
						32'd0);
				if (kind != BK_END_AFTER_CHUNK)
					push_chunk(blob, TYPE_IEND,
						(kind == BK_IEND_LONG) ? $urandom_range(1, 6) : 0,
						(kind == BK_IEND_BAD) ? one_bit : 32'd0);
			end
		end
		case (kind)
			BK_CUT: blob = blob[0 : $urandom_range(0, blob.size() - 2)];
			BK_FLIP: begin
				pos = $urandom_range(0, blob.size() - 1);
				blob[pos] = blob[pos] ^ (8'd1 << $urandom_range(0, 7));
			end
			BK_NO_LAST: begin
				blob = blob[0 : $urandom_range(0, blob.size() - 1)];
				mark_last = 0;
			end
			BK_TRAILING: begin
				// bytes after a finished parse are dropped until the next start mark
				repeat ($urandom_range(1, 5))
					blob.push_back(8'($urandom));
			end
			default: ;
		endcase
		for (int i = 0; i < blob.size(); i++)
			push_byte(blob[i], i == 0, mark_last && (i == blob.size() - 1));
		blobs_queued++;
	endtask

	function automatic blob_kind_e pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return BK_INTACT;
		if (r < 52) return BK_CUT;
		if (r < 64) return BK_FLIP;
		if (r < 70) return BK_TRAILING;
		if (r < 76) return BK_HUGE_LEN;
		if (r < 82) return BK_NO_LAST;
		if (r < 86) return BK_NOISE;
		if (r < 90) return BK_IHDR_BAD;
		if (r < 93) return BK_END_AT_IHDR;
		if (r < 96) return BK_END_AFTER_CHUNK;
		if (r < 98) return BK_IEND_LONG;
		return BK_IEND_BAD;
	endfunction

	function automatic void check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// driver: when no byte is pending or one completes, the next is put up unless the feed is empty or an idle is drawn
	always @(posedge clk) begin : byte_driver
		png_result_t res;
		byte_item_t nxt;
		if (arst_n) begin
			if (stream_if.valid && stream_if.ready) begin
				if (advance_parser(stream_if.data_byte, stream_if.first_byte,
						stream_if.last_byte, res))
					expected_results.push_back(res);
			end
			if (!stream_if.valid || stream_if.ready) begin
				if (byte_feed.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					nxt = byte_feed.pop_front();
					stream_if.data_byte <= nxt.data;
					stream_if.first_byte <= nxt.first;
					stream_if.last_byte <= nxt.last;
					stream_if.valid <= 1'b1;
				end else begin
					stream_if.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		png_result_t want;
		if (arst_n) begin
			if (result_if.valid && result_if.ready) begin
				results_checked++;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual status %0d w %h h %h len %h",
						$time, result_if.status, result_if.image_width,
						result_if.image_height, result_if.total_length);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					status_hits[want.status]++;
					check_field("status", 32'(want.status), 32'(result_if.status));
					check_field("image_width", want.width, result_if.image_width);
					check_field("image_height", want.height, result_if.image_height);
					check_field("total_length", want.length, result_if.total_length);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else if (hold_request && !hold_done) begin
				// long back-pressure so the input side fills and stalls
				hold_done = 1;
				hold_left = LONG_HOLD;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (stream_if.valid && stream_if.ready)
				|| (result_if.valid && result_if.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		stream_if.valid = 1'b0;
		stream_if.data_byte = 8'h00;
		stream_if.first_byte = 1'b0;
		stream_if.last_byte = 1'b0;
		result_if.ready = 1'b0;
		arst_n = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		parser_reset();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < 3; ph++) begin
			int target_bytes;
			int target_blobs;
			case (ph)
				0: begin send_idle_pct = 33; recv_idle_pct = 72; end
				1: begin send_idle_pct = 72; recv_idle_pct = 33; end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
					hold_request = 1;
				end
			endcase
			if (ph == 0) begin
				// stray bytes before any start mark, a one-byte blob, an early
				// signature mismatch and a blob ending right after the signature
				push_byte(8'h00, 1'b0, 1'b0);
				push_byte(8'hFF, 1'b0, 1'b1);
				push_byte(8'h89, 1'b1, 1'b1);
				push_byte(8'h00, 1'b1, 1'b0);
				push_byte(8'h55, 1'b0, 1'b1);
				for (int i = 0; i < 16; i++)
					push_byte(PNG_SIG[i], i == 0, i == 15);
				for (int k = 0; k < BK_COUNT; k++)
					queue_blob(blob_kind_e'(k));
			end
			target_bytes = bytes_queued + 170;
			target_blobs = blobs_queued + 2;
			while (bytes_queued < target_bytes || blobs_queued < target_blobs)
				queue_blob(pick_kind());
			while (byte_feed.size() != 0 || stream_if.valid)
				@(negedge clk);
		end

		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d bytes in %0d blobs, checked %0d results", bytes_queued,
			blobs_queued, results_checked);
		$display("Status mix: valid %0d, no sig %0d, trunc IHDR %0d, IHDR crc %0d, bounds %0d, chunk crc %0d, no IEND %0d",
			status_hits[0], status_hits[1], status_hits[2], status_hits[3],
			status_hits[4], status_hits[5], status_hits[6]);
		if (expected_results.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected_results.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: sim.f
rtl/pcsv_pkg.sv
rtl/pcsv_ifs.sv
rtl/pcsv_front.sv
rtl/pcsv_queue.sv
rtl/pcsv_back.sv
rtl/png_chunk_stream_validator_top.sv
tb/tb_png_chunk_stream_validator_top.sv
